// ===== hdl/crlm_pkg.sv =====
// Shared types, constants and helper functions for the cron line matcher.
`timescale 1ns / 1ps

package crlm_pkg;

  localparam int unsigned NUM_BITS   = 16;
  localparam int unsigned LINE_BITS  = 16;
  localparam int unsigned VAL_BITS   = 6;
  localparam int unsigned CFG_BITS   = 6;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned FIDX_BITS  = 3;

  localparam logic [FIDX_BITS-1:0] FIELD_COUNT = 3'd5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QCNT_BITS   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MINUTE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOUR    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MDAY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MONTH   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WEEKDAY = 3'd4;

  // Item parse phases.
  localparam logic [2:0] PH_S_WS   = 3'd0;
  localparam logic [2:0] PH_S_SIGN = 3'd1;
  localparam logic [2:0] PH_S_DIG  = 3'd2;
  localparam logic [2:0] PH_S_DONE = 3'd3;
  localparam logic [2:0] PH_H_WS   = 3'd4;
  localparam logic [2:0] PH_H_SIGN = 3'd5;
  localparam logic [2:0] PH_H_DIG  = 3'd6;
  localparam logic [2:0] PH_H_DONE = 3'd7;

  // Line kinds.
  localparam logic [1:0] KIND_BLANK   = 2'd0;
  localparam logic [1:0] KIND_FIELDS  = 2'd1;
  localparam logic [1:0] KIND_COMMENT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_BLANK   = 2'd2;
  localparam logic [1:0] ST_FEW     = 2'd3;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } crlm_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [LINE_BITS-1:0] line_number;
    logic                 match_found;
    logic                 last;
  } crlm_out_t;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [2:0] weekday;
  } crlm_time_t;

  typedef struct packed {
    logic [2:0]          phase;
    logic                seen;
    logic [NUM_BITS-1:0] low_bound;
    logic [NUM_BITS-1:0] high_bound;
    logic                low_negative;
    logic                high_negative;
    logic                has_range;
  } crlm_item_t;

  localparam crlm_item_t ITEM_CLEAR = '0;

  // Up to two results produced by one transaction, handed to the result queue.
  typedef struct packed {
    logic      first_valid;
    logic      second_valid;
    crlm_out_t first;
    crlm_out_t second;
  } crlm_res_pair_t;

  function automatic logic is_trim(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // m * 10 + digit, saturating at the largest magnitude.
  function automatic logic [NUM_BITS-1:0] accumulate(input logic [NUM_BITS-1:0] m,
                                                     input logic [7:0] c);
    logic [NUM_BITS+3:0] t;
    t = ({4'd0, m} << 3) + ({4'd0, m} << 1) + {{NUM_BITS{1'b0}}, c[3:0]};
    if (t[NUM_BITS+3:NUM_BITS] != 4'd0) begin
      return {NUM_BITS{1'b1}};
    end
    return t[NUM_BITS-1:0];
  endfunction

  function automatic logic [VAL_BITS-1:0] time_value(input logic [FIDX_BITS-1:0] idx,
                                                     input crlm_time_t t);
    logic [VAL_BITS-1:0] v;
    case (idx)
      3'd0:    v = t.minute;
      3'd1:    v = {1'b0, t.hour};
      3'd2:    v = {1'b0, t.day_of_month};
      3'd3:    v = {2'b0, t.month};
      3'd4:    v = {3'b0, t.weekday};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Compares the field's time value with a parsed item (negative zero is zero).
  function automatic logic item_eval(input crlm_item_t it, input logic [VAL_BITS-1:0] v);
    logic [NUM_BITS-1:0] vx;
    logic ge_lo, le_hi, eq;
    vx    = {{(NUM_BITS-VAL_BITS){1'b0}}, v};
    ge_lo = it.low_negative || (vx >= it.low_bound);
    le_hi = it.high_negative ? ((vx == '0) && (it.high_bound == '0))
                             : (vx <= it.high_bound);
    eq    = it.low_negative ? ((vx == '0) && (it.low_bound == '0))
                            : (vx == it.low_bound);
    return it.has_range ? (ge_lo && le_hi) : eq;
  endfunction

  function automatic crlm_item_t high_ws(input crlm_item_t it, input logic [7:0] c);
    crlm_item_t r;
    r = it;
    if (is_ws(c)) begin
      r.phase = PH_H_WS;
    end else if (c == CH_PLUS) begin
      r.phase = PH_H_SIGN;
    end else if (c == CH_MINUS) begin
      r.high_negative = 1'b1;
      r.phase = PH_H_SIGN;
    end else if (is_digit(c)) begin
      r.high_bound = accumulate(it.high_bound, c);
      r.phase = PH_H_DIG;
    end else begin
      r.phase = PH_H_DONE;
    end
    return r;
  endfunction

  function automatic crlm_item_t start_done(input crlm_item_t it, input logic [7:0] c);
    crlm_item_t r;
    r = it;
    if (c == CH_MINUS) begin
      r.has_range = 1'b1;
      r.phase = PH_H_WS;
    end else begin
      r.phase = PH_S_DONE;
    end
    return r;
  endfunction

  // One byte of the per-item number parser.
  function automatic crlm_item_t item_feed(input crlm_item_t it, input logic [7:0] c);
    crlm_item_t r;
    logic dig;
    r   = it;
    dig = is_digit(c);
    case (it.phase)
      PH_S_WS: begin
        if (!is_ws(c)) begin
          if (c == CH_PLUS) begin
            r.phase = PH_S_SIGN;
          end else if (c == CH_MINUS) begin
            r.low_negative = 1'b1;
            r.has_range = 1'b1;
            r.phase = PH_S_SIGN;
          end else if (dig) begin
            r.low_bound = accumulate(it.low_bound, c);
            r.phase = PH_S_DIG;
          end else begin
            r.phase = PH_S_DONE;
          end
        end
      end
      PH_S_SIGN, PH_S_DIG: begin
        if (dig) begin
          r.low_bound = accumulate(it.low_bound, c);
          if (it.has_range) r.high_bound = r.low_bound;
          r.phase = PH_S_DIG;
        end else if (it.has_range) begin
          if (it.phase == PH_S_SIGN) r = high_ws(it, c);
          else r.phase = PH_H_DONE;
        end else begin
          r = start_done(it, c);
        end
      end
      PH_S_DONE: begin
        if (c == CH_MINUS) begin
          r.has_range = 1'b1;
          r.phase = PH_H_WS;
        end
      end
      PH_H_WS: r = high_ws(it, c);
      PH_H_SIGN, PH_H_DIG: begin
        if (dig) begin
          r.high_bound = accumulate(it.high_bound, c);
          r.phase = PH_H_DIG;
        end else begin
          r.phase = PH_H_DONE;
        end
      end
      default: r = it;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/cron_line_matcher.sv =====
// Top level of the cron line matcher: ports, time registers and input register.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_ready_o / in_data_i) carries one crontab text
// byte per transaction, or an end-of-text marker. A newline closes a line and
// yields one result transaction with its status and line number, until some line
// matches; after that bytes are dropped until end of text. End of text yields the
// pending line's result (if any) followed by the summary, marked by last.
// The time to match against (minute, hour, day of month, month, weekday) is set
// through the write port cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write it
// only while the block is idle; the block itself does not enforce this.
// A byte held in the input register is parsed once the result queue has room for a
// full pair; its result is then written to the queue and offered on the output.
// Throughput: one transaction per cycle while the queue has room. Only an
// end-of-text transaction that carries two results adds an extra result, which the
// four-entry result queue absorbs. When the receiver stalls, the queue fills and
// in_ready_o drops once fewer than two entries are free; no result is lost or repeated.
// Reset clears all line state, the line counter and the match flag, and sets the
// time registers to minute 0, hour 0, day 1, month 1, weekday 0.

module cron_line_matcher (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  crlm_pkg::crlm_in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output crlm_pkg::crlm_out_t                    out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [crlm_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [crlm_pkg::CFG_BITS-1:0]          cfg_wdata_i
);
  import crlm_pkg::*;

  crlm_time_t     time_q;
  logic           in_valid_q;
  crlm_in_t       in_q;
  logic           room;
  logic           go;
  crlm_res_pair_t res;

  // The parser consumes the held byte whenever the queue can take a full pair.
  assign go         = in_valid_q && room;
  assign in_ready_o = !in_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Time registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '{minute: 6'd0, hour: 5'd0, day_of_month: 5'd1, month: 4'd1, weekday: 3'd0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MINUTE:  time_q.minute       <= cfg_wdata_i;
        CFG_HOUR:    time_q.hour         <= cfg_wdata_i[4:0];
        CFG_MDAY:    time_q.day_of_month <= cfg_wdata_i[4:0];
        CFG_MONTH:   time_q.month        <= cfg_wdata_i[3:0];
        CFG_WEEKDAY: time_q.weekday      <= cfg_wdata_i[2:0];
        default:     time_q              <= time_q;
      endcase
    end
  end

  crlm_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .in_i   (in_q),
    .time_i (time_q),
    .res_o  (res)
  );

  crlm_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/crlm_parser.sv =====
// Per-byte line parser and matcher: line state registers and result building.
`timescale 1ns / 1ps

module crlm_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  crlm_pkg::crlm_in_t       in_i,
  input  crlm_pkg::crlm_time_t     time_i,
  output crlm_pkg::crlm_res_pair_t res_o
);
  import crlm_pkg::*;

  logic [FIDX_BITS-1:0] field_index_q, field_index_d;
  logic [FIDX_BITS-1:0] pend_count_q, pend_count_d;
  logic                 line_ok_q, line_ok_d;
  logic                 field_hit_q, field_hit_d;
  logic                 field_wild_q, field_wild_d;
  logic                 at_start_q, at_start_d;
  logic                 field_real_q, field_real_d;
  logic                 pend_ok_q, pend_ok_d;
  logic                 byte_seen_q, byte_seen_d;
  logic                 line_cut_q, line_cut_d;
  logic [1:0]           line_kind_q, line_kind_d;
  crlm_item_t           item_q, item_d;
  logic [LINE_BITS-1:0] line_counter_q, line_counter_d;
  logic                 found_q, found_d;
  logic [LINE_BITS-1:0] found_line_q, found_line_d;

  logic [7:0]           c;
  logic [VAL_BITS-1:0]  fv;
  logic                 fld_match, fld_counts, fin_end;
  logic [FIDX_BITS-1:0] fin_fi, fin_pc;
  logic                 fin_ok, fin_found, clear_line;
  logic [1:0]           fin_st;
  logic [LINE_BITS-1:0] fin_line, fin_found_line;
  crlm_out_t            line_res;
  crlm_res_pair_t       pair;

  always_comb begin
    c = in_i.char_byte;
    field_index_d  = field_index_q;
    pend_count_d   = pend_count_q;
    line_ok_d      = line_ok_q;
    field_hit_d    = field_hit_q;
    field_wild_d   = field_wild_q;
    at_start_d     = at_start_q;
    field_real_d   = field_real_q;
    pend_ok_d      = pend_ok_q;
    byte_seen_d    = byte_seen_q;
    line_cut_d     = line_cut_q;
    line_kind_d    = line_kind_q;
    item_d         = item_q;
    line_counter_d = line_counter_q;
    found_d        = found_q;
    found_line_d   = found_line_q;
    clear_line     = 1'b0;
    pair           = '0;

    // Outcome of closing the current field.
    fv         = time_value(field_index_q, time_i);
    fld_match  = field_wild_q || field_hit_q || (item_q.seen && item_eval(item_q, fv));
    fld_counts = field_index_q < FIELD_COUNT;

    // Outcome of finishing the current line.
    fin_end = (line_kind_q == KIND_FIELDS) && !at_start_q;
    fin_fi  = field_index_q + {2'b0, fin_end && fld_counts};
    fin_pc  = pend_count_q + {2'b0, fin_end && fld_counts && !field_real_q};
    fin_ok  = line_ok_q && !(fin_end && fld_counts && field_real_q && !fld_match);
    if (line_kind_q != KIND_FIELDS) begin
      fin_st = ST_BLANK;
    end else if ((fin_fi - fin_pc) < FIELD_COUNT) begin
      fin_st = ST_FEW;
    end else begin
      fin_st = fin_ok ? ST_MATCH : ST_NOMATCH;
    end
    fin_line = (line_counter_q != {LINE_BITS{1'b1}}) ? line_counter_q + 1'b1
                                                      : line_counter_q;
    fin_found      = found_q || (fin_st == ST_MATCH);
    fin_found_line = (fin_st == ST_MATCH) ? fin_line : found_line_q;
    line_res = '{status: fin_st, line_number: fin_line, match_found: fin_found, last: 1'b0};

    if (go_i) begin
      if (in_i.end_of_text) begin
        pair.first_valid = 1'b1;
        if (!found_q && byte_seen_q) begin
          pair.first        = line_res;
          pair.second_valid = 1'b1;
          pair.second = '{status: fin_found ? ST_MATCH : ST_NOMATCH,
                          line_number: fin_found ? fin_found_line : '0,
                          match_found: fin_found, last: 1'b1};
        end else begin
          pair.first = '{status: found_q ? ST_MATCH : ST_NOMATCH,
                         line_number: found_q ? found_line_q : '0,
                         match_found: found_q, last: 1'b1};
        end
        line_counter_d = '0;
        found_d        = 1'b0;
        found_line_d   = '0;
        clear_line     = 1'b1;
      end else if (!found_q) begin
        if (c == CH_LF) begin
          pair.first_valid = 1'b1;
          pair.first       = line_res;
          line_counter_d   = fin_line;
          found_d          = fin_found;
          found_line_d     = fin_found_line;
          clear_line       = 1'b1;
        end else begin
          byte_seen_d = 1'b1;
          if (!line_cut_q && (line_kind_q != KIND_COMMENT)) begin
            if (c == CH_NUL) begin
              line_cut_d = 1'b1;
            end else if (!((line_kind_q == KIND_BLANK) && is_trim(c))) begin
              if ((line_kind_q == KIND_BLANK) && (c == CH_HASH)) begin
                line_kind_d = KIND_COMMENT;
              end else begin
                line_kind_d = KIND_FIELDS;
                if (c == CH_SP) begin
                  if (!at_start_q) begin
                    if (fld_counts) begin
                      if (field_real_q) begin
                        line_ok_d = line_ok_q && fld_match;
                      end else begin
                        pend_ok_d    = pend_ok_q && fld_match;
                        pend_count_d = pend_count_q + 1'b1;
                      end
                      field_index_d = field_index_q + 1'b1;
                    end
                    at_start_d = 1'b1;
                  end
                end else begin
                  if (at_start_q) begin
                    at_start_d   = 1'b0;
                    field_wild_d = c inside {CH_STAR, CH_LA, CH_LX};
                    field_hit_d  = 1'b0;
                    field_real_d = 1'b0;
                    item_d       = ITEM_CLEAR;
                  end
                  // A visible byte confirms any tab-only fields before it.
                  if (!is_trim(c) && !field_real_d) begin
                    field_real_d = 1'b1;
                    line_ok_d    = line_ok_d && pend_ok_d;
                    pend_count_d = '0;
                    pend_ok_d    = 1'b1;
                  end
                  if (c == CH_COMMA) begin
                    if (item_d.seen && item_eval(item_d, fv)) field_hit_d = 1'b1;
                    item_d = ITEM_CLEAR;
                  end else begin
                    item_d.seen = 1'b1;
                    item_d = item_feed(item_d, c);
                  end
                end
              end
            end
          end
        end
      end
    end

    if (clear_line) begin
      field_index_d = '0;
      pend_count_d  = '0;
      line_ok_d     = 1'b1;
      field_hit_d   = 1'b0;
      field_wild_d  = 1'b0;
      at_start_d    = 1'b1;
      field_real_d  = 1'b0;
      pend_ok_d     = 1'b1;
      byte_seen_d   = 1'b0;
      line_cut_d    = 1'b0;
      line_kind_d   = KIND_BLANK;
      item_d        = ITEM_CLEAR;
    end
  end

  assign res_o = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_index_q  <= '0;
      pend_count_q   <= '0;
      line_ok_q      <= 1'b1;
      field_hit_q    <= 1'b0;
      field_wild_q   <= 1'b0;
      at_start_q     <= 1'b1;
      field_real_q   <= 1'b0;
      pend_ok_q      <= 1'b1;
      byte_seen_q    <= 1'b0;
      line_cut_q     <= 1'b0;
      line_kind_q    <= KIND_BLANK;
      item_q         <= ITEM_CLEAR;
      line_counter_q <= '0;
      found_q        <= 1'b0;
      found_line_q   <= '0;
    end else begin
      field_index_q  <= field_index_d;
      pend_count_q   <= pend_count_d;
      line_ok_q      <= line_ok_d;
      field_hit_q    <= field_hit_d;
      field_wild_q   <= field_wild_d;
      at_start_q     <= at_start_d;
      field_real_q   <= field_real_d;
      pend_ok_q      <= pend_ok_d;
      byte_seen_q    <= byte_seen_d;
      line_cut_q     <= line_cut_d;
      line_kind_q    <= line_kind_d;
      item_q         <= item_d;
      line_counter_q <= line_counter_d;
      found_q        <= found_d;
      found_line_q   <= found_line_d;
    end
  end

`ifndef SYNTHESIS
  a_field_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_index_q <= FIELD_COUNT) else $error("field index past the last field");
  a_pending_le_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_count_q <= field_index_q) else $error("more pending fields than fields");
  a_second_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair.second_valid |-> (pair.first_valid && pair.second.last && !pair.first.last))
    else $error("second result is not a summary after a line result");
  a_quiet_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && found_q && !in_i.end_of_text) |-> !pair.first_valid)
    else $error("line result produced after a match");
`endif

endmodule

// ===== hdl/crlm_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and drains one when the receiver is ready.
`timescale 1ns / 1ps

module crlm_result_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  crlm_pkg::crlm_res_pair_t push_i,
  output logic                     room_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output crlm_pkg::crlm_out_t      out_data_o
);
  import crlm_pkg::*;

  crlm_out_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 pop;

  assign out_valid_o = count_q != '0;
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a full pair of results, judged on the registered count.
  assign room_o      = count_q <= QCNT_BITS'(QUEUE_DEPTH - 2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_BITS'(push_i.first_valid) + QPTR_BITS'(push_i.second_valid);
    rd_ptr_d = rd_ptr_q + QPTR_BITS'(pop);
    count_d  = count_q + QCNT_BITS'(push_i.first_valid) + QCNT_BITS'(push_i.second_valid)
             - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_valid) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.second_valid) begin
      entry_q[wr_ptr_q + 1'b1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_BITS'(QUEUE_DEPTH)) else $error("result queue overflow");
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first_valid |-> room_o) else $error("push into a queue without room");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second_valid |-> push_i.first_valid) else $error("second push without first");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.first_valid) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count wrong after a pop");
`endif

endmodule
